>>> design/indexed_insert_delete_list_macros.svh
// Assertion macros used by the list top level.
`ifndef INDEXED_INSERT_DELETE_LIST_MACROS_SVH
`define INDEXED_INSERT_DELETE_LIST_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define IIL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define IIL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list assertion failed");

`endif

>>> design/iil_pkg.sv
// Types and codes shared by the indexed insert/delete list.
`timescale 1ns / 1ps

package iil_pkg;

	localparam int WORD_W  = 32;
	localparam int POS_W   = 8;
	localparam int COUNT_W = 9;

	// Operation codes.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;

	typedef struct packed {
		logic [1:0]              op;
		logic [POS_W-1:0]        position;
		logic signed [WORD_W-1:0] data_in;
	} iil_req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] data_out;
		logic [COUNT_W-1:0]       count;
	} iil_rsp_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic              ins;
		logic              wr;
		logic              del;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] data;
	} iil_bcast_t;

endpackage

>>> design/iil_cell.sv
// One storage cell of the list chain, shifting to or from its neighbors.
`timescale 1ns / 1ps

module iil_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  iil_pkg::iil_bcast_t        bcast,
	input  logic [iil_pkg::WORD_W-1:0] left,
	input  logic [iil_pkg::WORD_W-1:0] right,
	output logic [iil_pkg::WORD_W-1:0] word
);
	import iil_pkg::*;

	localparam logic [POS_W-1:0] IDX_V = POS_W'(IDX);

	logic [WORD_W-1:0] word_q;

	// Insert moves entries above the position up; delete pulls them down.
	always_ff @(posedge clk) begin
		if (bcast.ins) begin
			if (IDX_V > bcast.pos) begin
				word_q <= left;
			end else if (IDX_V == bcast.pos) begin
				word_q <= bcast.data;
			end
		end else if (bcast.wr) begin
			if (IDX_V == bcast.pos) begin
				word_q <= bcast.data;
			end
		end else if (bcast.del) begin
			if (IDX_V >= bcast.pos) begin
				word_q <= right;
			end
		end
	end

	assign word = word_q;

endmodule

>>> design/indexed_insert_delete_list.sv
// Top level of the indexed insert/delete list.
// The list holds up to DEPTH signed 32-bit words packed from position 0, one word per cell
// in a row of cells. For an insert, write/append, delete or read, every cell loads from
// its left or right neighbor, from the request, or holds, all in the same cycle, so
// one transaction is accepted per clock while the result register is free or being
// taken. The result of a request is registered and appears on rsp in the cycle after
// acceptance; read and delete data come from a position-selected multiplexer over the
// cells. Errors (full, bad index) leave the list unchanged and return zero data. Cells
// are not cleared at reset; only the entry count and the result valid flag are.
`timescale 1ns / 1ps

module indexed_insert_delete_list #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  iil_pkg::iil_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output iil_pkg::iil_rsp_t rsp
);
	import iil_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam logic [COUNT_W-1:0] DEPTH_V = COUNT_W'(DEPTH);

	logic [CW-1:0]     cnt_q;
	logic              rsp_valid_q;
	iil_rsp_t          rsp_q;
	logic [WORD_W-1:0] cell_word [DEPTH];
	iil_bcast_t        bcast;
	logic              req_fire;
	logic [COUNT_W-1:0] cnt9;
	logic [COUNT_W-1:0] pos9;
	logic [COUNT_W-1:0] cnt_next;
	logic [1:0]        status;
	logic              take_word;
	logic [WORD_W-1:0] sel_word;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_fire  = req_valid && !req_stall;
	assign cnt9      = COUNT_W'(cnt_q);
	assign pos9      = {1'b0, req.position};
	assign sel_word  = cell_word[req.position[IW-1:0]];

	// Decide status, count change and which cells move.
	always_comb begin
		status    = ST_OK;
		take_word = 1'b0;
		cnt_next  = cnt9;
		bcast.ins = 1'b0;
		bcast.wr  = 1'b0;
		bcast.del = 1'b0;
		bcast.pos = req.position;
		bcast.data = req.data_in;
		unique case (req.op)
			OP_INSERT: begin
				if (cnt9 >= DEPTH_V) begin
					status = ST_FULL;
				end else if (pos9 > cnt9) begin
					status = ST_BAD_INDEX;
				end else begin
					bcast.ins = req_fire;
					cnt_next  = cnt9 + 1'b1;
				end
			end
			OP_WRITE: begin
				if (pos9 > cnt9) begin
					status = ST_BAD_INDEX;
				end else if (pos9 == cnt9) begin
					if (cnt9 >= DEPTH_V) begin
						status = ST_FULL;
					end else begin
						bcast.wr = req_fire;
						cnt_next = cnt9 + 1'b1;
					end
				end else begin
					bcast.wr = req_fire;
				end
			end
			OP_DELETE: begin
				if (pos9 >= cnt9) begin
					status = ST_BAD_INDEX;
				end else begin
					bcast.del = req_fire;
					take_word = 1'b1;
					cnt_next  = cnt9 - 1'b1;
				end
			end
			OP_READ: begin
				if (pos9 >= cnt9) begin
					status = ST_BAD_INDEX;
				end else begin
					take_word = 1'b1;
				end
			end
			default: begin
				status = ST_BAD_INDEX;
			end
		endcase
	end

	// Chain of cells; the ends take their own word or the request data.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = bcast.data;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_word[i];
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end
		iil_cell #(.IDX(i)) u_cell (
			.clk   (clk),
			.bcast (bcast),
			.left  (left_w),
			.right (right_w),
			.word  (cell_word[i])
		);
	end

	// Entry count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				cnt_q       <= cnt_next[CW-1:0];
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q.status   <= status;
			rsp_q.data_out <= take_word ? sel_word : '0;
			rsp_q.count    <= cnt_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "indexed_insert_delete_list_macros.svh"

	`IIL_ASSERT_NOW(a_count_bound, 1'b1, cnt9 <= DEPTH_V)
	`IIL_ASSERT_NEXT(a_fire_gives_rsp, req_fire, rsp_valid_q)
	`IIL_ASSERT_NOW(a_err_zero_data, rsp_valid_q && rsp_q.status != ST_OK, rsp_q.data_out == '0)
	`IIL_ASSERT_NOW(a_stall_has_rsp, req_stall, rsp_valid_q)

endmodule

>>> tb/tb.sv
// Self-checking testbench for the indexed insert/delete list.
`timescale 1ns / 1ps

module tb;
	import iil_pkg::*;

	localparam int LIST_DEPTH  = 16;
	localparam int IDLE_LIMIT  = 3000;
	localparam int ERROR_PRINT = 40;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	iil_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	iil_rsp_t rsp;

	// Shadow copy of the list contents and length.
	logic [WORD_W-1:0] shadow_cells [LIST_DEPTH];
	int                shadow_len = 0;

	// Results owed by the block, oldest first.
	iil_rsp_t pending_list_rsp [$];
	iil_rsp_t expected_head;

	int  error_count = 0;
	int  sent_count = 0;
	int  op_count [4] = '{0, 0, 0, 0};
	int  seen_ok = 0;
	int  seen_full = 0;
	int  seen_bad = 0;
	int  full_hits = 0;
	int  empty_hits = 0;
	int  idle_cycles = 0;
	int  stall_hold = 0;
	int  stall_roll;
	bit  sender_eager = 1'b0;

	indexed_insert_delete_list #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// Clock with a 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one request to the shadow list and return the result it must produce.
	function automatic iil_rsp_t apply_list_op(input iil_req_t r);
		iil_rsp_t o;
		int       p;
		int       i;
		o.status   = ST_OK;
		o.data_out = '0;
		p = int'(r.position);
		case (r.op)
			OP_INSERT: begin
				if (shadow_len >= LIST_DEPTH) begin
					o.status = ST_FULL;
				end else if (p > shadow_len) begin
					o.status = ST_BAD_INDEX;
				end else begin
					for (i = shadow_len; i > p; i--) begin
						shadow_cells[i] = shadow_cells[i-1];
					end
					shadow_cells[p] = r.data_in;
					shadow_len++;
				end
			end
			OP_WRITE: begin
				if (p > shadow_len) begin
					o.status = ST_BAD_INDEX;
				end else if (p == shadow_len) begin
					if (shadow_len >= LIST_DEPTH) begin
						o.status = ST_FULL;
					end else begin
						shadow_cells[p] = r.data_in;
						shadow_len++;
					end
				end else begin
					shadow_cells[p] = r.data_in;
				end
			end
			OP_DELETE: begin
				if (p >= shadow_len) begin
					o.status = ST_BAD_INDEX;
				end else begin
					o.data_out = shadow_cells[p];
					for (i = p; i + 1 < shadow_len; i++) begin
						shadow_cells[i] = shadow_cells[i+1];
					end
					shadow_len--;
				end
			end
			default: begin
				if (p >= shadow_len) begin
					o.status = ST_BAD_INDEX;
				end else begin
					o.data_out = shadow_cells[p];
				end
			end
		endcase
		o.count = COUNT_W'(shadow_len);
		return o;
	endfunction

	// Idle length before a request: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Mostly positions that hit the list or its end, sometimes anywhere.
	function automatic logic [POS_W-1:0] pick_position();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			return POS_W'($urandom_range(0, shadow_len));
		end else if (roll < 85) begin
			return POS_W'($urandom_range(shadow_len, shadow_len + 2));
		end
		return POS_W'($urandom_range(0, 255));
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= ERROR_PRINT) begin
			$display("mismatch at %0t ns: %s", $time, msg);
		end
	endtask

	// Present one request and hold it until the block takes the transaction.
	task automatic send_req(input logic [1:0] op, input logic [POS_W-1:0] pos,
			input logic [WORD_W-1:0] data);
		iil_req_t r;
		int       gap;
		r.op       = op;
		r.position = pos;
		r.data_in  = data;
		gap = sender_eager ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_list_rsp.push_back(apply_list_op(r));
		sent_count++;
		op_count[op]++;
		if (shadow_len == LIST_DEPTH) begin
			full_hits++;
		end
		if (shadow_len == 0) begin
			empty_hits++;
		end
	endtask

	// Stop sending and wait until every owed result has come back.
	task automatic wait_until_drained();
		req_valid <= 1'b0;
		while (pending_list_rsp.size() != 0) @(posedge clk);
	endtask

	// Operations against an empty list that must be rejected: reads, deletes, out-of-range writes and inserts.
	task automatic test_empty_list();
		send_req(OP_READ, 8'd0, 32'h1234_5678);
		send_req(OP_DELETE, 8'd0, 32'h0);
		send_req(OP_DELETE, 8'd255, 32'hFFFF_FFFF);
		send_req(OP_WRITE, 8'd1, 32'h0BAD_0001);
		send_req(OP_INSERT, 8'd1, 32'h0BAD_0002);
	endtask

	// Grow the list to capacity by inserts and appends, then push past it.
	task automatic test_fill_and_overflow();
		send_req(OP_INSERT, 8'd0, 32'h7FFF_FFFF);
		send_req(OP_INSERT, 8'd0, 32'h8000_0000);
		send_req(OP_WRITE, 8'd2, 32'hFFFF_FFFF);
		send_req(OP_WRITE, 8'd3, 32'h0000_0000);
		send_req(OP_INSERT, 8'd2, 32'h5A5A_A5A5);
		while (shadow_len < LIST_DEPTH) begin
			send_req(OP_WRITE, POS_W'(shadow_len), $urandom());
		end
		// Full takes precedence over a bad index on insert.
		send_req(OP_INSERT, 8'd255, 32'h1111_1111);
		send_req(OP_INSERT, 8'd0, 32'h2222_2222);
		send_req(OP_WRITE, POS_W'(LIST_DEPTH), 32'h3333_3333);
		send_req(OP_WRITE, POS_W'(LIST_DEPTH + 1), 32'h4444_4444);
		send_req(OP_WRITE, POS_W'(LIST_DEPTH - 1), 32'hA5A5_5A5A);
	endtask

	// Reads and deletes at both ends, in the middle and just past the end.
	task automatic test_drain_edges();
		send_req(OP_READ, POS_W'(LIST_DEPTH - 1), 32'h0);
		send_req(OP_READ, POS_W'(LIST_DEPTH), 32'h0);
		send_req(OP_DELETE, POS_W'(LIST_DEPTH - 1), 32'hDEAD_BEEF);
		send_req(OP_DELETE, 8'd0, 32'h0);
		send_req(OP_DELETE, 8'd7, 32'h0);
		send_req(OP_READ, 8'd0, 32'h0);
	endtask

	// Random traffic that swings between growing and shrinking the list.
	task automatic test_random_traffic(input int n);
		int         k;
		int         roll;
		bit         growing;
		logic [1:0] op;
		growing = 1'b1;
		for (k = 0; k < n; k++) begin
			if (k % 40 == 0) begin
				growing      = ~growing;
				sender_eager = ($urandom_range(0, 3) == 0);
			end
			roll = $urandom_range(0, 99);
			if (growing) begin
				op = (roll < 40) ? OP_INSERT : (roll < 70) ? OP_WRITE :
					(roll < 85) ? OP_DELETE : OP_READ;
			end else begin
				op = (roll < 15) ? OP_INSERT : (roll < 30) ? OP_WRITE :
					(roll < 70) ? OP_DELETE : OP_READ;
			end
			send_req(op, pick_position(), $urandom());
		end
		sender_eager = 1'b0;
	endtask

	// The sender goes quiet until the block has answered everything.
	task automatic test_pause_until_drained();
		int k;
		for (k = 0; k < 10; k++) begin
			send_req(2'($urandom_range(0, 3)), pick_position(), $urandom());
		end
		wait_until_drained();
		for (k = 0; k < 10; k++) begin
			send_req(2'($urandom_range(0, 3)), pick_position(), $urandom());
		end
	endtask

	// Receiver stalls: flowing stretches, short stalls and a few long ones.
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 55) begin
				rsp_stall  <= 1'b0;
				stall_hold <= $urandom_range(1, 20);
			end else if (stall_roll < 92) begin
				rsp_stall  <= 1'b1;
				stall_hold <= $urandom_range(1, 3);
			end else begin
				rsp_stall  <= 1'b1;
				stall_hold <= $urandom_range(8, 40);
			end
		end else begin
			stall_hold <= stall_hold - 1;
		end
	end

	// Compare each accepted result transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_list_rsp.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				expected_head = pending_list_rsp.pop_front();
				if (rsp.status !== expected_head.status) begin
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, expected_head.status));
				end
				if (rsp.data_out !== expected_head.data_out) begin
					report_mismatch($sformatf("data_out %h, expected %h",
						rsp.data_out, expected_head.data_out));
				end
				if (rsp.count !== expected_head.count) begin
					report_mismatch($sformatf("count %0d, expected %0d",
						rsp.count, expected_head.count));
				end
				case (expected_head.status)
					ST_OK:   seen_ok++;
					ST_FULL: seen_full++;
					default: seen_bad++;
				endcase
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_and_overflow();
		test_drain_edges();
		test_pause_until_drained();
		test_random_traffic(760);
		wait_until_drained();
		repeat (8) @(posedge clk);
		if (pending_list_rsp.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_list_rsp.size()));
		end
		$display("sent %0d requests: %0d insert, %0d write, %0d delete, %0d read",
			sent_count, op_count[OP_INSERT], op_count[OP_WRITE], op_count[OP_DELETE],
			op_count[OP_READ]);
		$display("results ok %0d, full %0d, bad index %0d; list full %0d times, empty %0d times",
			seen_ok, seen_full, seen_bad, full_hits, empty_hits);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
